// ===== src/subset_pairwise_distance_sum_assert.svh =====
// Assertion macros for the checker module of the distance-sum block.
`ifndef SUBSET_PAIRWISE_DISTANCE_SUM_ASSERT_SVH
`define SUBSET_PAIRWISE_DISTANCE_SUM_ASSERT_SVH

// Generic concurrent check on a given clock and active-low reset.
`define SPDS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The same check on the block's own clock and reset.
`define SPDS_ASSERT_CLK(lbl, prop, msg) `SPDS_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/spds_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spds_pkg
// Types, widths and codes shared by the pairwise distance-sum block.
// ---------------------------------------------------------------------------
package spds_pkg;

  // Field widths fixed by the stream format.
  localparam int ID_W       = 6;
  localparam int DIST_IN_W  = 16;
  localparam int SUM_W      = 23;
  localparam int UNI_W      = 7;
  localparam int SUB_W      = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSET   = 1'd1;
  localparam logic [UNI_W-1:0] UNI_RESET = 7'd64;
  localparam logic [SUB_W-1:0] SUB_RESET = 5'd16;

  // Operation codes carried in tuser.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_APPEND = 1'b1;

  // Parameter defaults.
  localparam int MAX_ELEMS_DEF  = 64;
  localparam int MAX_SUBSET_DEF = 16;
  localparam int DIST_BITS_DEF  = 16;

  // One request entering the index pipeline.
  typedef struct packed {
    logic vld;   // request present
    logic wr;    // distance write from the input word
    logic isp;   // member read that loads the outer member
  } pair_req_t;

  // Status returned by the index pipeline.
  typedef struct packed {
    logic busy;     // requests still in flight
    logic bad_hit;  // outer member loaded this cycle lies outside the universe
  } pipe_stat_t;

endpackage

// ===== src/spds_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spds_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module spds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== src/spds_pair_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spds_pair_pipe
// Packed-index pipeline: orders a pair, forms its triangular index, writes
// or reads the distance memory and accumulates the read distances.
// ---------------------------------------------------------------------------
module spds_pair_pipe #(
  parameter int MAX_ELEMS = spds_pkg::MAX_ELEMS_DEF,
  parameter int DIST_BITS = spds_pkg::DIST_BITS_DEF,
  localparam int N_W   = $clog2(MAX_ELEMS + 1),
  localparam int TRI_W = 2 * N_W
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire spds_pkg::pair_req_t           req_i,
  input  wire logic [spds_pkg::ID_W-1:0]     member_i,
  input  wire logic [spds_pkg::ID_W-1:0]     elem_a_i,
  input  wire logic [spds_pkg::ID_W-1:0]     elem_b_i,
  input  wire logic [DIST_BITS-1:0]          dist_i,
  input  wire logic [N_W-1:0]                n_i,
  input  wire logic [TRI_W-1:0]              tri_n_i,
  input  wire logic                          clr_i,
  output logic      [spds_pkg::SUM_W-1:0]    sum_o,
  output spds_pkg::pipe_stat_t               stat_o
);

  localparam int DEPTH = (MAX_ELEMS * (MAX_ELEMS - 1)) / 2;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (spds_pkg::ID_W > N_W) ? spds_pkg::ID_W : N_W;

  // Outer member of the running scan.
  logic [spds_pkg::ID_W-1:0] p_q;

  // Stage B combinational values.
  logic [spds_pkg::ID_W-1:0] p_val, q_val, lo, hi;
  logic                      pair_ok;
  logic [N_W-1:0]            r_val;
  logic [TRI_W-1:0]          prod;

  // Stage B registers.
  logic             b_vld_q, b_wr_q, b_ok_q;
  logic [TRI_W-1:0] b_tri_q, b_off_q;

  // Stage C values and registers.
  logic [TRI_W-1:0]     k_full;
  logic [IDX_W-1:0]     idx;
  logic                 c_vld_q;
  logic [DIST_BITS-1:0] rdata;

  logic [spds_pkg::SUM_W-1:0] sum_q;

  // Order the pair and check both ids against the universe.
  always_comb begin
    p_val   = req_i.wr ? elem_a_i : p_q;
    q_val   = req_i.wr ? elem_b_i : member_i;
    pair_ok = (CW'(p_val) < CW'(n_i)) && (CW'(q_val) < CW'(n_i)) && (p_val != q_val);
    lo      = (p_val < q_val) ? p_val : q_val;
    hi      = (p_val < q_val) ? q_val : p_val;
    r_val   = n_i - N_W'(lo);
    prod    = TRI_W'(r_val) * TRI_W'(r_val - N_W'(1));
  end

  // Stage B: triangular term of the remaining rows and the column offset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= req_i.vld && !req_i.isp;
    end
  end

  always_ff @(posedge clk_i) begin
    b_wr_q  <= req_i.wr;
    b_ok_q  <= pair_ok;
    b_tri_q <= prod >> 1;
    b_off_q <= TRI_W'(hi - lo - spds_pkg::ID_W'(1));
    if (req_i.vld && req_i.isp) begin
      p_q <= member_i;
    end
  end

  assign stat_o.bad_hit = req_i.vld && req_i.isp && (CW'(member_i) >= CW'(n_i));

  // Stage C: packed index into the distance memory.
  assign k_full = tri_n_i - b_tri_q + b_off_q;
  assign idx    = k_full[IDX_W-1:0];

  spds_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (DEPTH)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (b_vld_q && b_wr_q && b_ok_q),
    .waddr_i (idx),
    .wdata_i (dist_i),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q && !b_wr_q && b_ok_q;
    end
  end

  // Stage D: accumulate the distance read for a valid pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (clr_i) begin
      sum_q <= '0;
    end else if (c_vld_q) begin
      sum_q <= sum_q + spds_pkg::SUM_W'(rdata);
    end
  end

  assign sum_o       = sum_q;
  assign stat_o.busy = b_vld_q || c_vld_q;

endmodule
`default_nettype wire

// ===== src/subset_pairwise_distance_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A distance write holds off the next word until the write has passed the
// request register and stage B of the pair pipeline. A member append that
// does not complete a subset leaves the input ready for the next word. The
// append that completes a subset of m members starts a scan over the member
// memory that issues one read per cycle, m reads of the outer member plus
// m*(m-1)/2 pair reads, followed by a drain of the pair pipeline before the
// next word is accepted. The single read port of the member memory and the
// one-pair-per-cycle distance pipeline set the pace of the scan. The result
// waits in an output register, so input words are taken while it is not yet
// read.
// Distance entries are undefined until written; no clearing pass runs.
// ---------------------------------------------------------------------------
// subset_pairwise_distance_sum
// Packed upper-triangular distance store with subset scoring: sums the
// distances over all pairs of distinct appended members inside the universe.
// ---------------------------------------------------------------------------
module subset_pairwise_distance_sum #(
  parameter int MAX_ELEMS  = spds_pkg::MAX_ELEMS_DEF,
  parameter int MAX_SUBSET = spds_pkg::MAX_SUBSET_DEF,
  parameter int DIST_BITS  = spds_pkg::DIST_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input words.
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: elem_a [5:0], elem_b [11:6], dist_value [27:12], zero [31:28]
  input  wire logic [spds_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // tuser: func [0]
  input  wire logic                                s_axis_tuser_i,
  // Result words.
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // tdata: total_distance [22:0], zero [23]
  output logic      [spds_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // tuser: bad_member [0]
  output logic                                     m_axis_tuser_o,
  // Configuration writes.
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [spds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [spds_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int N_W   = $clog2(MAX_ELEMS + 1);
  localparam int TRI_W = 2 * N_W;
  localparam int CNT_W = $clog2(MAX_SUBSET + 2);
  localparam int MA_W  = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
  localparam int CW    = (spds_pkg::ID_W > N_W) ? spds_pkg::ID_W : N_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [spds_pkg::UNI_W-1:0] uni_q;
  logic [spds_pkg::SUB_W-1:0] sub_q;
  logic [N_W-1:0]             n_eff;
  logic [CNT_W-1:0]           m_eff;
  logic [TRI_W-1:0]           tri_n_q;

  // Word fields.
  logic [spds_pkg::ID_W-1:0] in_a, in_b;
  logic [DIST_BITS-1:0]      in_dist;
  logic                      in_acc;

  // Held word.
  logic [spds_pkg::ID_W-1:0] a_q, b_q;
  logic [DIST_BITS-1:0]      dist_q;
  logic                      func_q;

  // Member bookkeeping and scan counters.
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             bad_q, bad_d;
  logic [CNT_W-1:0] x_q, x_d, y_q, y_d, x_nxt;
  logic             mem_we;
  logic [MA_W-1:0]  mem_raddr;
  logic [spds_pkg::ID_W-1:0] member;

  // Stage A request and pipeline status.
  spds_pkg::pair_req_t  req_q, req_d;
  spds_pkg::pipe_stat_t stat;
  logic [spds_pkg::SUM_W-1:0] sum;
  logic pipe_empty, emit, clr;

  // Output register.
  logic                       out_vld_q;
  logic [spds_pkg::SUM_W-1:0] out_sum_q;
  logic                       out_bad_q;

  assign in_a    = s_axis_tdata_i[5:0];
  assign in_b    = s_axis_tdata_i[11:6];
  assign in_dist = DIST_BITS'(s_axis_tdata_i[27:12]);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uni_q <= spds_pkg::UNI_RESET;
      sub_q <= spds_pkg::SUB_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spds_pkg::CFG_UNIVERSE: uni_q <= cfg_data_i[spds_pkg::UNI_W-1:0];
        spds_pkg::CFG_SUBSET:   sub_q <= cfg_data_i[spds_pkg::SUB_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers to their usable ranges.
  always_comb begin
    if (32'(uni_q) < 2) begin
      n_eff = N_W'(2);
    end else if (32'(uni_q) > MAX_ELEMS) begin
      n_eff = N_W'(MAX_ELEMS);
    end else begin
      n_eff = N_W'(uni_q);
    end
    if (32'(sub_q) < 1) begin
      m_eff = CNT_W'(1);
    end else if (32'(sub_q) > MAX_SUBSET) begin
      m_eff = CNT_W'(MAX_SUBSET);
    end else begin
      m_eff = CNT_W'(sub_q);
    end
  end

  // Number of stored pairs for the current universe, refreshed every cycle.
  always_ff @(posedge clk_i) begin
    tri_n_q <= (TRI_W'(n_eff) * TRI_W'(n_eff - N_W'(1))) >> 1;
  end

  assign pipe_empty = !req_q.vld && !stat.busy;
  assign x_nxt      = x_q + CNT_W'(1);
  assign cnt_inc    = (32'(cnt_q) < MAX_SUBSET) ? cnt_q + CNT_W'(1) : cnt_q;
  assign mem_we     = in_acc && (s_axis_tuser_i == spds_pkg::FUNC_APPEND) &&
                      (32'(cnt_q) < MAX_SUBSET);

  // Control sequencer: word acceptance, member scan and drain.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    bad_d     = bad_q || stat.bad_hit;
    x_d       = x_q;
    y_d       = y_q;
    req_d     = '{vld: 1'b0, wr: 1'b0, isp: 1'b0};
    mem_raddr = x_q[MA_W-1:0];
    emit      = 1'b0;
    clr       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == spds_pkg::FUNC_WRITE) begin
            req_d   = '{vld: 1'b1, wr: 1'b1, isp: 1'b0};
            state_d = ST_DRAIN;
          end else begin
            cnt_d = cnt_inc;
            if (CW'(in_a) >= CW'(n_eff)) begin
              bad_d = 1'b1;
            end
            if (cnt_inc >= m_eff) begin
              x_d     = '0;
              y_d     = '0;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (y_q <= x_q) begin
          // Load the outer member.
          mem_raddr = x_q[MA_W-1:0];
          req_d     = '{vld: 1'b1, wr: 1'b0, isp: 1'b1};
          y_d       = x_nxt;
        end else if (y_q < cnt_q) begin
          // Inner member against the held outer one.
          mem_raddr = y_q[MA_W-1:0];
          req_d     = '{vld: 1'b1, wr: 1'b0, isp: 1'b0};
          y_d       = y_q + CNT_W'(1);
        end else if (x_nxt < cnt_q) begin
          mem_raddr = x_nxt[MA_W-1:0];
          req_d     = '{vld: 1'b1, wr: 1'b0, isp: 1'b1};
          x_d       = x_nxt;
          y_d       = x_nxt + CNT_W'(1);
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          if (func_q == spds_pkg::FUNC_APPEND) begin
            if (!out_vld_q || m_axis_tready_i) begin
              emit    = 1'b1;
              clr     = 1'b1;
              cnt_d   = '0;
              bad_d   = 1'b0;
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      req_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
      x_q     <= x_d;
      y_q     <= y_d;
      req_q   <= req_d;
    end
  end

  // Hold the accepted word for the pipeline.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q    <= in_a;
      b_q    <= in_b;
      dist_q <= in_dist;
      func_q <= s_axis_tuser_i;
    end
  end

  // Member list memory.
  spds_ram #(
    .WIDTH (spds_pkg::ID_W),
    .DEPTH (MAX_SUBSET)
  ) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[MA_W-1:0]),
    .wdata_i (in_a),
    .raddr_i (mem_raddr),
    .rdata_o (member)
  );

  spds_pair_pipe #(
    .MAX_ELEMS (MAX_ELEMS),
    .DIST_BITS (DIST_BITS)
  ) u_pair_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .member_i (member),
    .elem_a_i (a_q),
    .elem_b_i (b_q),
    .dist_i   (dist_q),
    .n_i      (n_eff),
    .tri_n_i  (tri_n_q),
    .clr_i    (clr),
    .sum_o    (sum),
    .stat_o   (stat)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_sum_q <= sum;
      out_bad_q <= bad_q || stat.bad_hit;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = spds_pkg::OUT_DATA_W'(out_sum_q);
  assign m_axis_tuser_o  = out_bad_q;

endmodule
`default_nettype wire

// ===== src/spds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spds_checker
// Port-level checks of the distance-sum block, bound to its top level.
// ---------------------------------------------------------------------------
`include "subset_pairwise_distance_sum_assert.svh"

module spds_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid_i,
  input wire logic                                s_axis_tready_o,
  input wire logic                                s_axis_tuser_i,
  input wire logic                                m_axis_tvalid_o,
  input wire logic                                m_axis_tready_i,
  input wire logic [spds_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input wire logic                                m_axis_tuser_o
);

  // A stalled result word holds its contents.
  `SPDS_ASSERT_CLK(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  // A distance write never produces a result word.
  `SPDS_ASSERT_CLK(a_write_silent, s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == spds_pkg::FUNC_WRITE) && !m_axis_tvalid_o |=> !m_axis_tvalid_o, "result after a distance write")

  // A new result only appears at the end of a scan, when input was held off.
  `SPDS_ASSERT_CLK(a_emit_after_scan, $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o), "result without a preceding scan")

endmodule

bind subset_pairwise_distance_sum spds_checker u_spds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

// ===== test/tb_subset_pairwise_distance_sum.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_subset_pairwise_distance_sum
// Self-checking bench for the pairwise distance-sum block. Distance writes and
// member appends are streamed in under random gaps and predicted with a local
// copy of the distance store and member list. Every score word is checked
// against the oldest predicted score.
// ---------------------------------------------------------------------------
module tb_subset_pairwise_distance_sum;
  import spds_pkg::*;

  localparam int STORE_DEPTH  = MAX_ELEMS_DEF * (MAX_ELEMS_DEF - 1) / 2;
  localparam int DRAIN_CYCLES = 16;
  localparam int END_CYCLES   = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  // One input word and one score word, split into their fields.
  typedef struct packed {
    bit                 func;
    bit [ID_W-1:0]      id_a;
    bit [ID_W-1:0]      id_b;
    bit [DIST_IN_W-1:0] dval;
  } req_word_t;

  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             bad;
  } score_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  subset_pairwise_distance_sum dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Shadow of the block: distance store, member list and registers.
  bit [DIST_IN_W-1:0] dist_mem [STORE_DEPTH];
  bit                 written [STORE_DEPTH];
  bit [ID_W-1:0]      held [MAX_SUBSET_DEF];
  int                 held_count = 0;
  bit                 bad_flag = 1'b0;
  logic [UNI_W-1:0]   uni_reg = UNI_RESET;
  logic [SUB_W-1:0]   sub_reg = SUB_RESET;

  req_word_t word_queue [$];
  score_t    sums_due [$];
  int        words_made = 0;
  int        fail_count = 0;
  int        cycle_count = 0;

  bit word_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_n();
    if (uni_reg < 2) return 2;
    if (uni_reg > MAX_ELEMS_DEF) return MAX_ELEMS_DEF;
    return int'(uni_reg);
  endfunction

  function automatic int eff_m();
    if (sub_reg < 1) return 1;
    if (sub_reg > MAX_SUBSET_DEF) return MAX_SUBSET_DEF;
    return int'(sub_reg);
  endfunction

  // Compact upper-triangular slot of the pair lo < hi < n.
  function automatic int pair_slot(int lo, int hi, int n);
    int r;
    if (lo >= hi || hi >= n) return STORE_DEPTH;
    r = n - lo;
    return (n * n - n) / 2 - (r * r - r) / 2 + hi - lo - 1;
  endfunction

  // Applies one accepted word to the shadow and queues the score it causes.
  function automatic void score_word(req_word_t w);
    int        n, k, lo, hi;
    bit [31:0] sum;
    score_t    s;
    n = eff_n();
    if (w.func == FUNC_WRITE) begin
      lo = (w.id_a < w.id_b) ? w.id_a : w.id_b;
      hi = (w.id_a < w.id_b) ? w.id_b : w.id_a;
      k = pair_slot(lo, hi, n);
      if (k < STORE_DEPTH) begin
        dist_mem[k] = w.dval;
        written[k] = 1'b1;
      end
    end else begin
      if (held_count < MAX_SUBSET_DEF) begin
        held[held_count] = w.id_a;
        held_count++;
      end
      if (w.id_a >= n) bad_flag = 1'b1;
      if (held_count >= eff_m() || held_count >= MAX_SUBSET_DEF) begin
        sum = '0;
        s.bad = bad_flag;
        // Members outside the universe add nothing but mark the score.
        for (int x = 0; x < held_count; x++) begin
          if (held[x] >= n) s.bad = 1'b1;
          else for (int y = x + 1; y < held_count; y++) begin
            if (held[y] < n && held[y] != held[x]) begin
              lo = (held[x] < held[y]) ? held[x] : held[y];
              hi = (held[x] < held[y]) ? held[y] : held[x];
              sum += dist_mem[pair_slot(lo, hi, n)];
            end
          end
        end
        s.total = sum[SUM_W-1:0];
        sums_due.push_back(s);
        held_count = 0;
        bad_flag = 1'b0;
      end
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 30);
  endfunction

  function automatic bit [DIST_IN_W-1:0] rand_dval();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DIST_IN_W'($urandom_range(65535));
  endfunction

  task automatic put_word(input bit func, input bit [ID_W-1:0] a, input bit [ID_W-1:0] b,
                          input bit [DIST_IN_W-1:0] d);
    req_word_t w;
    w = '{func: func, id_a: a, id_b: b, dval: d};
    // Writes with equal ids or an id outside the universe are dropped.
    if (func == FUNC_APPEND || (a != b && a < eff_n() && b < eff_n())) words_made++;
    word_queue.push_back(w);
    score_word(w);
  endtask

  task automatic put_pair(input bit [ID_W-1:0] a, input bit [ID_W-1:0] b,
                          input bit [DIST_IN_W-1:0] d);
    put_word(FUNC_WRITE, a, b, d);
  endtask

  // Appends a member. If it completes the subset, any pair distance that the
  // sum will read and that was never stored is written first.
  task automatic put_member(input bit [ID_W-1:0] id);
    bit [ID_W-1:0] ids [$];
    int            n, lo, hi;
    n = eff_n();
    for (int x = 0; x < held_count; x++) ids.push_back(held[x]);
    if (held_count < MAX_SUBSET_DEF) ids.push_back(id);
    if (ids.size() >= eff_m() || ids.size() >= MAX_SUBSET_DEF) begin
      for (int x = 0; x < ids.size(); x++) begin
        for (int y = x + 1; y < ids.size(); y++) begin
          lo = (ids[x] < ids[y]) ? ids[x] : ids[y];
          hi = (ids[x] < ids[y]) ? ids[y] : ids[x];
          if (lo != hi && hi < n && !written[pair_slot(lo, hi, n)]) begin
            if ($urandom_range(1)) put_pair(ID_W'(hi), ID_W'(lo), rand_dval());
            else put_pair(ID_W'(lo), ID_W'(hi), rand_dval());
          end
        end
      end
    end
    put_word(FUNC_APPEND, id, ID_W'($urandom_range(63)), DIST_IN_W'($urandom_range(65535)));
  endtask

  // Sixteen distinct members, every pair at the largest distance.
  task automatic put_full_subset();
    bit [ID_W-1:0] ids [MAX_SUBSET_DEF];
    for (int i = 0; i < MAX_SUBSET_DEF - 1; i++) ids[i] = ID_W'(i * 4);
    ids[MAX_SUBSET_DEF-1] = '1;
    for (int x = 0; x < MAX_SUBSET_DEF; x++) begin
      for (int y = x + 1; y < MAX_SUBSET_DEF; y++) put_pair(ids[y], ids[x], '1);
    end
    for (int x = 0; x < MAX_SUBSET_DEF; x++) put_member(ids[x]);
  endtask

  task automatic random_word();
    int            n, r;
    bit [ID_W-1:0] a, b;
    n = eff_n();
    r = $urandom_range(99);
    a = ID_W'($urandom_range(n - 1));
    b = ID_W'($urandom_range(n - 2));
    if (b >= a) b++;
    if (r < 8) begin
      // Noise: a write the block must drop.
      if (n < MAX_ELEMS_DEF && r[0]) b = ID_W'($urandom_range(63, n));
      else b = a;
      put_pair(a, b, rand_dval());
    end else if (r < 35) begin
      if (r[0]) put_pair(a, b, rand_dval());
      else put_pair(b, a, rand_dval());
    end else begin
      put_member(($urandom_range(9) == 0) ? ID_W'($urandom_range(63)) : a);
    end
  endtask

  // Waits until every queued word is taken and every score has come out.
  task automatic settle(input int extra);
    while (word_queue.size() > 0 || sums_due.size() > 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_UNIVERSE) uni_reg = val[UNI_W-1:0];
    else sub_reg = val[SUB_W-1:0];
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] uni, input logic [CFG_DATA_W-1:0] sub,
                           input int count, input bit full, input bit hold, input bit pause);
    int target;
    settle(DRAIN_CYCLES);
    set_reg(CFG_UNIVERSE, uni);
    set_reg(CFG_SUBSET, sub);
    target = words_made + count;
    if (hold) hold_req = 1'b1;
    if (full) put_full_subset();
    while (words_made < target) begin
      random_word();
      if (pause && words_made >= target - count / 2) begin
        settle(0);
        pause = 1'b0;
      end
    end
  endtask

  // Input side: a word leaves the queue once the block takes it.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready_o) begin
      void'(word_queue.pop_front());
      word_taken = 1'b1;
    end
  end

  // Input driver: offers the oldest pending word, with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni && (word_taken || !s_axis_tvalid)) begin
      word_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (word_queue.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, word_queue[0].dval, word_queue[0].id_b, word_queue[0].id_a};
        s_axis_tuser <= word_queue[0].func;
        if ($urandom_range(63) == 0) in_steady = !in_steady;
        in_gap = in_steady ? 0 : gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted on its own.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
  end

  // Score-side ready with random stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(63) == 0) out_steady = !out_steady;
        out_gap = out_steady ? 0 : gap_len();
      end
    end
  end

  // Score checker: each word against the oldest prediction.
  always @(posedge clk_i) begin
    score_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      got.total = m_axis_tdata_o[SUM_W-1:0];
      got.bad = m_axis_tuser_o;
      if (sums_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected score word: total %0d bad %0b", $realtime,
                   got.total, got.bad);
      end else begin
        want = sums_due.pop_front();
        if (got.total !== want.total || got.bad !== want.bad) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] score mismatch: expected total %0d bad %0b, got total %0d bad %0b",
                     $realtime, want.total, want.bad, got.total, got.bad);
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extreme ids and distances, reversed pairs, overwrite,
    // dropped writes, equal members.
    set_reg(CFG_SUBSET, 7'd2);
    put_pair(6'd63, 6'd0, 16'hFFFF);
    put_pair(6'd5, 6'd5, 16'h1234);
    put_member(6'd0);
    put_member(6'd63);
    put_pair(6'd62, 6'd63, 16'hAAAA);
    put_pair(6'd63, 6'd62, 16'h0000);
    put_member(6'd63);
    put_member(6'd62);
    put_pair(6'd1, 6'd0, 16'h5555);
    put_member(6'd1);
    put_member(6'd0);
    put_member(6'd7);
    put_member(6'd7);

    // Members outside the universe, and a write with an out-of-range id.
    settle(DRAIN_CYCLES);
    set_reg(CFG_UNIVERSE, 7'd10);
    set_reg(CFG_SUBSET, 7'd3);
    put_pair(6'd3, 6'd12, 16'h7777);
    put_pair(6'd2, 6'd3, 16'h0F0F);
    put_member(6'd2);
    put_member(6'd12);
    put_member(6'd3);

    // Universe shrinks and subset size drops while two members are held.
    put_member(6'd9);
    put_member(6'd4);
    settle(DRAIN_CYCLES);
    set_reg(CFG_UNIVERSE, 7'd5);
    set_reg(CFG_SUBSET, 7'd1);
    put_member(6'd1);

    // Random phases over several register settings, the extremes among them.
    run_phase(7'd64, 7'd16, 150, 1'b1, 1'b0, 1'b0);
    run_phase(7'd8, 7'd4, 60, 1'b0, 1'b0, 1'b0);
    run_phase(7'd3, 7'd2, 40, 1'b0, 1'b1, 1'b0);
    run_phase(7'd20, 7'd6, 50, 1'b0, 1'b0, 1'b1);
    run_phase(7'd0, 7'd0, 25, 1'b0, 1'b0, 1'b0);
    run_phase(7'd127, 7'd31, 50, 1'b0, 1'b0, 1'b0);
    run_phase(7'd12, 7'd97, 30, 1'b0, 1'b0, 1'b0);
    run_phase(7'd2, 7'd3, 25, 1'b0, 1'b0, 1'b0);
    run_phase(7'd40, 7'd5, 50, 1'b0, 1'b0, 1'b0);

    settle(END_CYCLES);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
